FILE: rtl/ppp_pkg.sv
// Package for the perspective point projector: widths, status codes,
// register indexes and shared types. No dependencies.
`timescale 1ns / 1ps
package ppp_pkg;

  localparam int COORD_W   = 32;
  localparam int COEF_W    = 16;
  localparam int PROD_W    = COORD_W + COEF_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int COMP_W    = SUM_W - 12;
  localparam int AW        = COMP_W + 2;
  localparam int SIZE_W    = 13;
  localparam int DW        = COMP_W + 1;
  localparam int RW        = DW + 1;
  localparam int NW        = AW + SIZE_W + 16;
  localparam int QW        = 32;
  localparam int DIV_LAT   = QW + 2;
  localparam int W_EPS     = 65;

  typedef enum logic [2:0] {
    ST_OK   = 3'd0,
    ST_ZERO = 3'd1,
    ST_NEAR = 3'd2,
    ST_FAR  = 3'd3,
    ST_WIN  = 3'd4,
    ST_OVF  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    REG_ROW0   = 3'd0,
    REG_ROW1   = 3'd1,
    REG_ROW2   = 3'd2,
    REG_ROW3   = 3'd3,
    REG_WIDTH  = 3'd4,
    REG_HEIGHT = 3'd5
  } reg_idx_t;

  typedef logic signed [COMP_W-1:0] comp_t;

  typedef struct packed {
    logic          big;
    logic          neg;
    logic          wz;
    logic [QW-1:0] q;
  } div_res_t;

endpackage

FILE: rtl/perspective_point_projector_unit.sv
// Top level of the perspective point projector: config registers, clip
// tests, viewport finish and output register. Depends on ppp_pkg, ppp_mac, ppp_div.
//
//   channel  dir  handshake           payload
//   in_      in   in_tvalid/tready    in_tdata  (x, y, z, test_mask)
//   out_     out  out_tvalid/tready   out_tdata (status, screen_x, screen_y)
//   cfg_     in   cfg_we              cfg_addr, cfg_data
//
// One point per cycle while out_ is not stalled.
// Most of the pipeline is the 32-stage restoring divider per axis.
// Reset (synchronous, rst_n low) clears all valid bits and loads the identity
// matrix and a 1920x1080 viewport. A stall on out_ freezes the whole pipeline.
`timescale 1ns / 1ps
module perspective_point_projector_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,   // point_x, point_y, point_z, test_mask
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [71:0]  out_tdata,  // status, screen_x, screen_y
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [63:0]  cfg_data
);

  localparam int LINE = ppp_pkg::DIV_LAT;

  logic [3:0][63:0]             rows_r;
  logic [ppp_pkg::SIZE_W-1:0]   vw_r, vh_r;
  logic                         en;

  logic                         v1_r, v2_r, v3_r;
  logic [3:0]                   m1_r, m2_r;
  logic                         vl_r [LINE];
  ppp_pkg::status_t             stl_r [LINE];
  logic                         wml_r [LINE];

  ppp_pkg::comp_t               comp [4];
  logic [ppp_pkg::COMP_W-1:0]   w_r;
  logic [ppp_pkg::AW-1:0]       ax_r, ay_r;
  logic                         nx_r, ny_r;
  ppp_pkg::status_t             st3_r;
  logic                         wm3_r;

  ppp_pkg::div_res_t            rx, ry;

  logic                         out_valid_r;
  logic [71:0]                  out_data_r;

  assign en         = !out_valid_r || out_tready;
  assign in_tready  = en;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r[0] <= 64'd4096;
      rows_r[1] <= 64'd4096 << 16;
      rows_r[2] <= 64'd4096 << 32;
      rows_r[3] <= 64'd4096 << 48;
      vw_r      <= 13'd1920;
      vh_r      <= 13'd1080;
    end else if (cfg_we) begin
      case (cfg_addr)
        ppp_pkg::REG_ROW0:   rows_r[0] <= cfg_data;
        ppp_pkg::REG_ROW1:   rows_r[1] <= cfg_data;
        ppp_pkg::REG_ROW2:   rows_r[2] <= cfg_data;
        ppp_pkg::REG_ROW3:   rows_r[3] <= cfg_data;
        ppp_pkg::REG_WIDTH:  vw_r <= cfg_data[ppp_pkg::SIZE_W-1:0];
        ppp_pkg::REG_HEIGHT: vh_r <= cfg_data[ppp_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  ppp_mac u_mac (
    .clk  (clk),
    .en   (en),
    .x    (in_tdata[31:0]),
    .y    (in_tdata[63:32]),
    .z    (in_tdata[95:64]),
    .rows (rows_r),
    .comp (comp)
  );

  // clip tests and numerators
  logic [ppp_pkg::COMP_W-1:0]   w_nxt;
  logic signed [ppp_pkg::AW-1:0] ws, zs, nx, ny;
  ppp_pkg::status_t             st_nxt;

  always_comb begin
    w_nxt = comp[3][ppp_pkg::COMP_W-1] ? ppp_pkg::COMP_W'(-comp[3])
                                       : ppp_pkg::COMP_W'(comp[3]);
    ws = ppp_pkg::AW'(w_nxt);
    zs = ppp_pkg::AW'(comp[2]);
    nx = ws + ppp_pkg::AW'(comp[0]);
    ny = ws + ppp_pkg::AW'(comp[1]);
    if (m2_r[0] && (w_nxt <= ppp_pkg::COMP_W'(ppp_pkg::W_EPS)))
      st_nxt = ppp_pkg::ST_ZERO;
    else if (m2_r[1] && (zs <= -ws))
      st_nxt = ppp_pkg::ST_NEAR;
    else if (m2_r[2] && (zs >= ws))
      st_nxt = ppp_pkg::ST_FAR;
    else
      st_nxt = ppp_pkg::ST_OK;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r  <= in_tdata[99:96];
      m2_r  <= m1_r;
      w_r   <= w_nxt;
      nx_r  <= nx[ppp_pkg::AW-1];
      ny_r  <= ny[ppp_pkg::AW-1];
      ax_r  <= nx[ppp_pkg::AW-1] ? -nx : nx;
      ay_r  <= ny[ppp_pkg::AW-1] ? -ny : ny;
      st3_r <= st_nxt;
      wm3_r <= m2_r[3];
      stl_r[0] <= st3_r;
      wml_r[0] <= wm3_r;
      for (int i = 1; i < LINE; i++) begin
        stl_r[i] <= stl_r[i-1];
        wml_r[i] <= wml_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      for (int i = 0; i < LINE; i++) vl_r[i] <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      vl_r[0] <= v3_r;
      for (int i = 1; i < LINE; i++) vl_r[i] <= vl_r[i-1];
    end
  end

  ppp_div u_div_x (
    .clk (clk), .en (en), .a (ax_r), .neg (nx_r), .w (w_r), .size (vw_r), .res (rx)
  );

  ppp_div u_div_y (
    .clk (clk), .en (en), .a (ay_r), .neg (ny_r), .w (w_r), .size (vh_r), .res (ry)
  );

  // finish: sign, overflow, window
  function automatic logic axis_ovf(ppp_pkg::div_res_t r);
    logic over;
    over = r.q[ppp_pkg::QW-1] && (r.q[ppp_pkg::QW-2:0] != '0);
    return !r.wz && (r.big || over || (!r.neg && r.q == {1'b1, {(ppp_pkg::QW-1){1'b0}}}));
  endfunction

  function automatic logic signed [ppp_pkg::QW:0] axis_val(ppp_pkg::div_res_t r,
                                                          logic [ppp_pkg::SIZE_W-1:0] s);
    logic signed [ppp_pkg::QW:0] v;
    if (r.wz)
      v = (ppp_pkg::QW+1)'({s, 15'b0});
    else if (r.neg)
      v = -(ppp_pkg::QW+1)'(r.q);
    else
      v = (ppp_pkg::QW+1)'(r.q);
    return v;
  endfunction

  logic                         ox, oy, wx, wy;
  logic signed [ppp_pkg::QW:0]  fx, fy;
  ppp_pkg::status_t             st_fin;
  logic [71:0]                  out_nxt;

  always_comb begin
    ox = axis_ovf(rx);
    oy = axis_ovf(ry);
    fx = axis_val(rx, vw_r);
    fy = axis_val(ry, vh_r);
    wx = ox || (fx <= 0) || (fx >= (ppp_pkg::QW+1)'({vw_r, 16'b0}));
    wy = oy || (fy <= 0) || (fy >= (ppp_pkg::QW+1)'({vh_r, 16'b0}));
    if (stl_r[LINE-1] != ppp_pkg::ST_OK)
      st_fin = stl_r[LINE-1];
    else if (wml_r[LINE-1] && (wx || wy))
      st_fin = ppp_pkg::ST_WIN;
    else if (ox || oy)
      st_fin = ppp_pkg::ST_OVF;
    else
      st_fin = ppp_pkg::ST_OK;
    out_nxt = '0;
    out_nxt[2:0] = st_fin;
    if (st_fin == ppp_pkg::ST_OK) begin
      out_nxt[34:3]  = fx[ppp_pkg::QW-1:0];
      out_nxt[66:35] = fy[ppp_pkg::QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vl_r[LINE-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_nxt;
    end
  end

endmodule

FILE: rtl/ppp_mac.sv
// Matrix-vector stage: 12 products, then four row sums floored to Q16.16.
// Two register stages. Depends on ppp_pkg.
`timescale 1ns / 1ps
module ppp_mac (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [ppp_pkg::COORD_W-1:0] x,
  input  logic signed [ppp_pkg::COORD_W-1:0] y,
  input  logic signed [ppp_pkg::COORD_W-1:0] z,
  input  logic [3:0][63:0]                 rows,
  output ppp_pkg::comp_t                   comp [4]
);

  logic signed [ppp_pkg::PROD_W-1:0] prod_r [4][3];
  logic signed [ppp_pkg::PROD_W-1:0] prod_nxt [4][3];
  logic signed [ppp_pkg::COEF_W-1:0] c3_r [4];
  ppp_pkg::comp_t                    comp_r [4];
  ppp_pkg::comp_t                    comp_nxt [4];

  always_comb begin
    logic signed [ppp_pkg::COEF_W-1:0] c;
    logic signed [ppp_pkg::SUM_W-1:0]  s;
    for (int r = 0; r < 4; r++) begin
      c = rows[r][ppp_pkg::COEF_W-1:0];
      prod_nxt[r][0] = c * x;
      c = rows[r][16 +: ppp_pkg::COEF_W];
      prod_nxt[r][1] = c * y;
      c = rows[r][32 +: ppp_pkg::COEF_W];
      prod_nxt[r][2] = c * z;
      s = ppp_pkg::SUM_W'(prod_r[r][0]) + ppp_pkg::SUM_W'(prod_r[r][1])
        + ppp_pkg::SUM_W'(prod_r[r][2]) + (ppp_pkg::SUM_W'(c3_r[r]) <<< 16);
      comp_nxt[r] = s[ppp_pkg::SUM_W-1:12];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        for (int k = 0; k < 3; k++) prod_r[r][k] <= prod_nxt[r][k];
        c3_r[r]   <= rows[r][48 +: ppp_pkg::COEF_W];
        comp_r[r] <= comp_nxt[r];
      end
    end
  end

  assign comp = comp_r;

endmodule

FILE: rtl/ppp_div.sv
// One viewport axis: a*size*2^16 by split multiply, then a 32-stage
// restoring divider by 2w, one quotient bit per stage. Depends on ppp_pkg.
`timescale 1ns / 1ps
module ppp_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [ppp_pkg::AW-1:0]        a,
  input  logic                          neg,
  input  logic [ppp_pkg::COMP_W-1:0]    w,
  input  logic [ppp_pkg::SIZE_W-1:0]    size,
  output ppp_pkg::div_res_t             res
);

  localparam int HALF = ppp_pkg::AW / 2;
  localparam int PW   = HALF + ppp_pkg::SIZE_W;
  localparam int MW   = ppp_pkg::AW + ppp_pkg::SIZE_W;

  logic [PW-1:0]           plo_r, phi_r;
  logic [ppp_pkg::DW-1:0]  dm_r;
  logic                    negm_r, wzm_r;

  logic [ppp_pkg::RW-1:0]  rem_r [ppp_pkg::QW+1];
  logic [ppp_pkg::QW-1:0]  lo_r  [ppp_pkg::QW+1];
  logic [ppp_pkg::QW-1:0]  q_r   [ppp_pkg::QW+1];
  logic [ppp_pkg::DW-1:0]  d_r   [ppp_pkg::QW+1];
  logic                    big_r [ppp_pkg::QW+1];
  logic                    neg_r [ppp_pkg::QW+1];
  logic                    wz_r  [ppp_pkg::QW+1];

  logic [MW-1:0]           m_sum;
  logic [ppp_pkg::NW-1:0]  n_full;
  logic [ppp_pkg::NW-ppp_pkg::QW-1:0] n_hi;

  assign m_sum  = {phi_r, HALF'(0)} + MW'(plo_r);
  assign n_full = {m_sum, 16'b0};
  assign n_hi   = n_full[ppp_pkg::NW-1:ppp_pkg::QW];

  always_ff @(posedge clk) begin
    if (en) begin
      plo_r  <= PW'(a[HALF-1:0]) * PW'(size);
      phi_r  <= PW'(a[ppp_pkg::AW-1:HALF]) * PW'(size);
      dm_r   <= {w, 1'b0};
      negm_r <= neg;
      wzm_r  <= (w == '0);

      rem_r[0] <= ppp_pkg::RW'(n_hi);
      lo_r[0]  <= n_full[ppp_pkg::QW-1:0];
      q_r[0]   <= '0;
      d_r[0]   <= dm_r;
      big_r[0] <= ppp_pkg::RW'(n_hi) >= ppp_pkg::RW'(dm_r);
      neg_r[0] <= negm_r;
      wz_r[0]  <= wzm_r;
    end
  end

  for (genvar i = 0; i < ppp_pkg::QW; i++) begin : g_step
    logic [ppp_pkg::RW-1:0] t;
    logic                   ge;
    assign t  = {rem_r[i][ppp_pkg::RW-2:0], lo_r[i][ppp_pkg::QW-1]};
    assign ge = t >= ppp_pkg::RW'(d_r[i]);
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1] <= ge ? t - ppp_pkg::RW'(d_r[i]) : t;
        lo_r[i+1]  <= {lo_r[i][ppp_pkg::QW-2:0], 1'b0};
        q_r[i+1]   <= {q_r[i][ppp_pkg::QW-2:0], ge};
        d_r[i+1]   <= d_r[i];
        big_r[i+1] <= big_r[i];
        neg_r[i+1] <= neg_r[i];
        wz_r[i+1]  <= wz_r[i];
      end
    end
  end

  assign res.big = big_r[ppp_pkg::QW];
  assign res.neg = neg_r[ppp_pkg::QW];
  assign res.wz  = wz_r[ppp_pkg::QW];
  assign res.q   = q_r[ppp_pkg::QW];

endmodule
